>>> src/bsmm_pkg.sv
// ----------------------------------------------------------------------------
// Bounded stack package
// Sizes, request codes and status codes used by the stack block.
// ----------------------------------------------------------------------------
package bsmm_pkg;

	// Number of words the stack can hold.
	localparam int unsigned DEPTH   = 256;
	localparam int unsigned ADDR_W  = $clog2(DEPTH);
	localparam int unsigned COUNT_W = $clog2(DEPTH + 1);
	localparam int unsigned WORD_W  = 32;
	localparam int unsigned REQ_W   = 3;
	localparam int unsigned STAT_W  = 2;
	// Result count field on the output bus.
	localparam int unsigned OUT_COUNT_W = 9;
	localparam int unsigned OUT_DATA_W  = ((WORD_W + OUT_COUNT_W + 7) / 8) * 8;

	typedef enum logic [REQ_W-1:0] {
		REQ_PUSH  = 3'd0,
		REQ_POP   = 3'd1,
		REQ_CLEAR = 3'd2,
		REQ_PEEK  = 3'd3,
		REQ_MAX   = 3'd4,
		REQ_MIN   = 3'd5
	} req_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK       = 2'd0,
		STAT_EMPTY    = 2'd1,
		STAT_BADPEEK  = 2'd2,
		STAT_OVERFLOW = 2'd3
	} status_t;

endpackage

>>> src/bounded_stack_with_min_max.sv
// ----------------------------------------------------------------------------
// Bounded stack with peek, max and min
// LIFO of signed 32-bit words held in one synchronous RAM, with scans.
// ----------------------------------------------------------------------------
// Latency: push, pop, clear, unused codes and rejected requests give their
// result in the cycle after the item is taken; a peek reads the RAM and then
// registers the word, and a max or min scan makes one RAM read per stored word.
// Throughput: one item at a time; the next item is taken once the result
// register is free and the single RAM read port is done with the last one.
// Reset clears the word count and the handshake state; RAM contents are kept.
// ----------------------------------------------------------------------------
module bounded_stack_with_min_max (
	input  logic                               clk,
	input  logic                               arst_n,
	// Request channel.
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [bsmm_pkg::WORD_W-1:0]        s_tdata,  // [31:0] operand
	input  logic [bsmm_pkg::REQ_W-1:0]         s_tuser,  // [2:0] req_type
	// Result channel.
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [bsmm_pkg::OUT_DATA_W-1:0]    m_tdata,  // [31:0] read_value,
	                                                     // [40:32] entry_count
	output logic [bsmm_pkg::STAT_W-1:0]        m_tuser   // [1:0] status
);

	localparam int unsigned AW = bsmm_pkg::ADDR_W;
	localparam int unsigned CW = bsmm_pkg::COUNT_W;
	localparam int unsigned WW = bsmm_pkg::WORD_W;

	// Sequencer states. The RAM is written only in idle and read by peek and
	// scan afterwards, so a read never overlaps a write to the same entry.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PEEK,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t                  state_q;
	logic [CW-1:0]           count_q;
	logic [CW-1:0]           idx_q;
	logic                    first_q;
	logic                    want_max_q;
	logic [WW-1:0]           best_q;
	logic                    m_tvalid_q;
	logic [WW-1:0]           out_value_q;
	bsmm_pkg::status_t       out_status_q;
	logic [CW-1:0]           out_count_q;

	logic                    accept;
	logic                    out_free;
	logic                    full;
	logic                    peek_ok;
	logic [CW-1:0]           peek_pos;
	bsmm_pkg::req_t          req;
	logic                    wr_en;
	logic                    rd_en;
	logic [AW-1:0]           rd_addr;
	logic [WW-1:0]           rd_data;
	logic                    take_best;

	assign req      = bsmm_pkg::req_t'(s_tuser);
	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE) && out_free;
	assign accept   = s_tvalid && s_tready;
	assign full     = (count_q == CW'(bsmm_pkg::DEPTH));

	// A peek depth is valid only below the current count; the entry sits that
	// far below the top, so its address is count - 1 - depth.
	assign peek_ok  = s_tdata < WW'(count_q);
	assign peek_pos = count_q - CW'(1) - CW'(s_tdata[AW-1:0]);

	assign wr_en = accept && (req == bsmm_pkg::REQ_PUSH) && !full;

	// RAM read port: one read for a peek, then one read per stored word for
	// a scan, walking upward from the bottom entry.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		if (accept && (req == bsmm_pkg::REQ_PEEK) && peek_ok) begin
			rd_en   = 1'b1;
			rd_addr = peek_pos[AW-1:0];
		end else if (accept && (req == bsmm_pkg::REQ_MAX || req == bsmm_pkg::REQ_MIN)
				&& (count_q != '0)) begin
			rd_en   = 1'b1;
			rd_addr = '0;
		end else if ((state_q == ST_SCAN) && (idx_q != count_q)) begin
			rd_en   = 1'b1;
			rd_addr = idx_q[AW-1:0];
		end
	end

	bsmm_ram #(
		.WIDTH (WW),
		.DEPTH (bsmm_pkg::DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[AW-1:0]),
		.wr_data (s_tdata),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// During a scan the word read last cycle replaces the running extreme
	// when it is the first word or beats the current one.
	always_comb begin
		if (first_q) begin
			take_best = 1'b1;
		end else if (want_max_q) begin
			take_best = $signed(rd_data) > $signed(best_q);
		end else begin
			take_best = $signed(rd_data) < $signed(best_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			idx_q        <= '0;
			first_q      <= 1'b0;
			want_max_q   <= 1'b0;
			best_q       <= '0;
			m_tvalid_q   <= 1'b0;
			out_value_q  <= '0;
			out_status_q <= bsmm_pkg::STAT_OK;
			out_count_q  <= '0;
		end else begin
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						out_value_q  <= '0;
						out_status_q <= bsmm_pkg::STAT_OK;
						out_count_q  <= count_q;
						unique case (req)
							bsmm_pkg::REQ_PUSH: begin
								m_tvalid_q <= 1'b1;
								if (full) begin
									out_status_q <= bsmm_pkg::STAT_OVERFLOW;
								end else begin
									count_q     <= count_q + CW'(1);
									out_count_q <= count_q + CW'(1);
								end
							end
							bsmm_pkg::REQ_POP: begin
								m_tvalid_q <= 1'b1;
								if (count_q == '0) begin
									out_status_q <= bsmm_pkg::STAT_EMPTY;
								end else begin
									count_q     <= count_q - CW'(1);
									out_count_q <= count_q - CW'(1);
								end
							end
							bsmm_pkg::REQ_CLEAR: begin
								m_tvalid_q  <= 1'b1;
								count_q     <= '0;
								out_count_q <= '0;
							end
							bsmm_pkg::REQ_PEEK: begin
								if (peek_ok) begin
									state_q <= ST_PEEK;
								end else begin
									m_tvalid_q   <= 1'b1;
									out_status_q <= bsmm_pkg::STAT_BADPEEK;
								end
							end
							bsmm_pkg::REQ_MAX, bsmm_pkg::REQ_MIN: begin
								if (count_q == '0) begin
									m_tvalid_q   <= 1'b1;
									out_status_q <= bsmm_pkg::STAT_EMPTY;
								end else begin
									state_q    <= ST_SCAN;
									idx_q      <= CW'(1);
									first_q    <= 1'b1;
									want_max_q <= (req == bsmm_pkg::REQ_MAX);
								end
							end
							default: begin
								// Unused codes report ok with the count unchanged.
								m_tvalid_q <= 1'b1;
							end
						endcase
					end
				end
				ST_PEEK: begin
					if (out_free) begin
						m_tvalid_q  <= 1'b1;
						out_value_q <= rd_data;
						state_q     <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					first_q <= 1'b0;
					if (take_best) begin
						best_q <= rd_data;
					end
					if (idx_q == count_q) begin
						state_q <= ST_DONE;
					end else begin
						idx_q <= idx_q + CW'(1);
					end
				end
				ST_DONE: begin
					if (out_free) begin
						m_tvalid_q  <= 1'b1;
						out_value_q <= best_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {(bsmm_pkg::OUT_DATA_W - WW - CW)'(0), out_count_q, out_value_q};

`ifndef SYNTHESIS
	// The count never passes the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(bsmm_pkg::DEPTH))
		else $error("stack count above capacity");

	// An accepted push to a stack that is not full grows the count by one.
	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> count_q == $past(count_q) + CW'(1))
		else $error("push did not advance the count");

	// The RAM is never written while a scan or peek is reading it.
	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> state_q == ST_IDLE)
		else $error("RAM written outside idle");

	// The scan index stays within the stored words.
	a_scan_index: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> (idx_q != '0) && (idx_q <= count_q))
		else $error("scan index out of range");
`endif

endmodule

>>> src/bsmm_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents are not reset.
// ----------------------------------------------------------------------------
module bsmm_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		// Read data holds until the next read is issued.
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
